/* rtl/spc_pkg.sv */
// shared types, constants and codes for the serial pwm command parser
package spc_pkg;

  localparam int PERIOD_BITS_DEF = 16;

  localparam int CHAR_W  = 8;
  localparam int TICK_W  = 24;
  localparam int FREQ_W  = 16;
  localparam int OUT_W   = 16;
  localparam int DUTY_W  = 7;
  localparam int ACC_W   = 17;
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [ACC_W-1:0]  ACC_MAX  = 17'd131071;
  localparam logic [ACC_W-1:0]  DUTY_MAX = 17'd100;
  localparam logic [FREQ_W-1:0] PCT_DIVISOR = 16'd100;

  localparam logic [TICK_W-1:0] TICK_RATE_RST      = 24'd1000000;
  localparam logic [FREQ_W-1:0] FREQ_LIMIT_RST     = 16'd4095;
  localparam logic [FREQ_W-1:0] INITIAL_PERIOD_RST = 16'd1000;

  localparam logic [CHAR_W-1:0] CH_DUTY  = 8'h64;  // 'd'
  localparam logic [CHAR_W-1:0] CH_FREQ  = 8'h66;  // 'f'
  localparam logic [CHAR_W-1:0] CH_TERM  = 8'h3B;  // ';'
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [CHAR_W-1:0] CH_RED   = 8'h72;  // 'r'
  localparam logic [CHAR_W-1:0] CH_GREEN = 8'h67;  // 'g'
  localparam logic [CHAR_W-1:0] CH_BLUE  = 8'h62;  // 'b'

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICK_RATE      = 2'd0,
    CFG_FREQ_LIMIT     = 2'd1,
    CFG_INITIAL_PERIOD = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FREQ,
    S_MUL_GO,
    S_MUL,
    S_CMP,
    S_DONE
  } state_t;

  // decision taken on a terminator, valid in the cycle a request is accepted
  typedef struct packed {
    logic              duty_ok;
    logic              freq_ok;
    logic [DUTY_W-1:0] duty;
    logic [FREQ_W-1:0] freq;
  } cmd_t;

endpackage

/* rtl/serial_pwm_command_parser_top.sv */
// serial pwm command parser: handshake, settings registers and sequencer
//
// Characters come in on rx_char with in_valid/in_ready; each accepted
// character yields exactly one result on the output channel (out_valid /
// out_ready) carrying period, compare, duty_percent, the three led states
// and applied. Results sit in an output register; the next character is
// taken once its result has moved into that register, so a stalled
// receiver holds at most one result plus one finished character.
// Most characters need no arithmetic. A ';' that
// accepts a frequency runs the serial divider over DIV_W bits
// (max(24, PERIOD_BITS + 7)), then the shift-add multiply and a second
// DIV_W-bit divide by 100 for the compare value. A ';' that only changes
// duty, or the first character after initial_period was rewritten, skips
// the first divide. One character is in flight at a time.
// Synchronous reset clears the command state, loads the register reset
// values and sets the period value to the initial_period reset value.
// Configuration writes take effect at once, initial_period only until a
// frequency has been applied. Configuration writes are to be made only
// while the block is idle; the block itself does not enforce this.
module serial_pwm_command_parser_top
  import spc_pkg::*;
#(
  parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CHAR_W-1:0]    rx_char,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_W-1:0]     period,
  output logic [OUT_W-1:0]     compare,
  output logic [DUTY_W-1:0]    duty_percent,
  output logic                 led_red,
  output logic                 led_green,
  output logic                 led_blue,
  output logic                 applied
);

  localparam int PROD_W = PERIOD_BITS + DUTY_W;
  localparam int DIV_W  = (PROD_W > TICK_W) ? PROD_W : TICK_W;

  state_t state, state_next;

  logic [TICK_W-1:0]      tick_rate;
  logic [FREQ_W-1:0]      freq_limit;
  logic [PERIOD_BITS-1:0] period_value;
  logic [DUTY_W-1:0]      duty_value;
  logic [OUT_W-1:0]       compare_value;
  logic                   freq_loaded;
  logic                   cmp_stale;
  logic                   applied_hold;

  logic                   accept;
  logic                   out_load;
  cmd_t                   cmd;
  logic [2:0]             leds;

  logic                   div_start;
  logic                   div_busy;
  logic [DIV_W-1:0]       div_dividend;
  logic [FREQ_W-1:0]      div_divisor;
  logic [DIV_W-1:0]       quotient;
  logic                   mul_start;
  logic                   mul_busy;
  logic [PROD_W-1:0]      product;

  assign accept = in_valid && in_ready;

  spc_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .rx_char    (rx_char),
    .freq_limit (freq_limit),
    .cmd        (cmd),
    .leds       (leds)
  );

  spc_mul #(
    .PERIOD_BITS (PERIOD_BITS)
  ) u_mul (
    .clk      (clk),
    .rst      (rst),
    .start    (mul_start),
    .duty     (duty_value),
    .mcand_in (period_value),
    .busy     (mul_busy),
    .product  (product)
  );

  spc_div #(
    .DVD_W (DIV_W),
    .DVS_W (FREQ_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // shared divider: tick_rate / freq from idle, product / 100 after multiply
  always_comb begin
    if (state == S_IDLE) begin
      div_dividend = DIV_W'(tick_rate);
      div_divisor  = cmd.freq;
    end else begin
      div_dividend = DIV_W'(product);
      div_divisor  = PCT_DIVISOR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    mul_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          priority if (cmd.freq_ok) begin
            div_start  = 1'b1;
            state_next = S_FREQ;
          end else if (cmd.duty_ok || cmp_stale) begin
            state_next = S_MUL_GO;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_FREQ: begin
        if (!div_busy) begin
          state_next = S_MUL_GO;
        end
      end
      S_MUL_GO: begin
        mul_start  = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        if (!mul_busy) begin
          div_start  = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (!div_busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // settings and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate     <= TICK_RATE_RST;
      freq_limit    <= FREQ_LIMIT_RST;
      period_value  <= PERIOD_BITS'(INITIAL_PERIOD_RST);
      duty_value    <= '0;
      compare_value <= '0;
      freq_loaded   <= 1'b0;
      cmp_stale     <= 1'b0;
      applied_hold  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_TICK_RATE: begin
            tick_rate <= cfg_data[TICK_W-1:0];
          end
          CFG_FREQ_LIMIT: begin
            freq_limit <= cfg_data[FREQ_W-1:0];
          end
          CFG_INITIAL_PERIOD: begin
            if (!freq_loaded) begin
              period_value <= PERIOD_BITS'(cfg_data[FREQ_W-1:0]);
              cmp_stale    <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      if (accept) begin
        applied_hold <= cmd.duty_ok || cmd.freq_ok;
        if (cmd.duty_ok) begin
          duty_value <= cmd.duty;
        end
      end
      if (state == S_FREQ && !div_busy) begin
        period_value <= quotient[PERIOD_BITS-1:0];
        freq_loaded  <= 1'b1;
      end
      if (state == S_CMP && !div_busy) begin
        compare_value <= quotient[OUT_W-1:0];
        cmp_stale     <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      period       <= OUT_W'(period_value);
      compare      <= compare_value;
      duty_percent <= duty_value;
      led_red      <= leds[0];
      led_green    <= leds[1];
      led_blue     <= leds[2];
      applied      <= applied_hold;
    end
  end

endmodule

/* rtl/spc_parser.sv */
// character decoder: mode flags, decimal accumulators and led toggles
module spc_parser
  import spc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [CHAR_W-1:0] rx_char,
  input  logic [FREQ_W-1:0] freq_limit,
  output cmd_t              cmd,
  output logic [2:0]        leds
);

  logic             duty_armed, duty_armed_next;
  logic             freq_armed, freq_armed_next;
  logic [ACC_W-1:0] duty_accum, duty_accum_next;
  logic [ACC_W-1:0] freq_accum, freq_accum_next;
  logic             duty_seen, duty_seen_next;
  logic             freq_seen, freq_seen_next;
  logic [2:0]       led_bits, led_bits_next;

  logic             is_term;
  logic             is_digit;
  logic [3:0]       digit;
  logic [ACC_W-1:0] acc_src;
  logic [ACC_W+3:0] acc_wide;
  logic [ACC_W-1:0] acc_sat;

  assign is_term  = (rx_char == CH_TERM);
  assign is_digit = (rx_char >= CH_ZERO) && (rx_char <= CH_NINE);
  assign digit    = rx_char[3:0];

  // times ten as two shifts, saturating
  assign acc_src  = duty_armed ? duty_accum : freq_accum;
  assign acc_wide = {1'b0, acc_src, 3'b000} + {3'b000, acc_src, 1'b0} + {17'd0, digit};
  assign acc_sat  = (acc_wide > {4'd0, ACC_MAX}) ? ACC_MAX : acc_wide[ACC_W-1:0];

  assign cmd.duty_ok = is_term && duty_seen && (duty_accum <= DUTY_MAX);
  assign cmd.freq_ok = is_term && freq_seen && (freq_accum != '0)
                       && (freq_accum <= {1'b0, freq_limit});
  assign cmd.duty = duty_accum[DUTY_W-1:0];
  assign cmd.freq = freq_accum[FREQ_W-1:0];

  assign leds = led_bits;

  always_comb begin
    duty_armed_next = duty_armed;
    freq_armed_next = freq_armed;
    duty_accum_next = duty_accum;
    freq_accum_next = freq_accum;
    duty_seen_next  = duty_seen;
    freq_seen_next  = freq_seen;
    led_bits_next   = led_bits;
    if (accept) begin
      priority if (rx_char == CH_DUTY) begin
        duty_armed_next = 1'b1;
      end else if (rx_char == CH_FREQ) begin
        freq_armed_next = 1'b1;
      end else if (is_term) begin
        duty_armed_next = 1'b0;
        freq_armed_next = 1'b0;
        duty_accum_next = '0;
        freq_accum_next = '0;
        duty_seen_next  = 1'b0;
        freq_seen_next  = 1'b0;
      end else if (is_digit) begin
        if (duty_armed) begin
          duty_accum_next = acc_sat;
          duty_seen_next  = 1'b1;
        end else if (freq_armed) begin
          freq_accum_next = acc_sat;
          freq_seen_next  = 1'b1;
        end
      end else if (!(duty_armed && freq_armed)) begin
        if (rx_char == CH_RED) begin
          led_bits_next = led_bits ^ 3'b001;
        end else if (rx_char == CH_GREEN) begin
          led_bits_next = led_bits ^ 3'b010;
        end else if (rx_char == CH_BLUE) begin
          led_bits_next = led_bits ^ 3'b100;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_armed <= 1'b0;
      freq_armed <= 1'b0;
      duty_accum <= '0;
      freq_accum <= '0;
      duty_seen  <= 1'b0;
      freq_seen  <= 1'b0;
      led_bits   <= '0;
    end else begin
      duty_armed <= duty_armed_next;
      freq_armed <= freq_armed_next;
      duty_accum <= duty_accum_next;
      freq_accum <= freq_accum_next;
      duty_seen  <= duty_seen_next;
      freq_seen  <= freq_seen_next;
      led_bits   <= led_bits_next;
    end
  end

endmodule

/* rtl/spc_mul.sv */
// bit-serial shift-add multiplier: duty percent times period
module spc_mul
  import spc_pkg::*;
#(
  parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [DUTY_W-1:0]             duty,
  input  logic [PERIOD_BITS-1:0]        mcand_in,
  output logic                          busy,
  output logic [PERIOD_BITS+DUTY_W-1:0] product
);

  localparam int CNT_W = $clog2(DUTY_W + 1);

  logic [PERIOD_BITS-1:0]        mcand;
  logic [PERIOD_BITS+DUTY_W-1:0] prod;
  logic [CNT_W-1:0]              count;
  logic [PERIOD_BITS:0]          sum;

  // upper half gathers partial sums, lower half shifts out multiplier bits
  assign sum = {1'b0, prod[PERIOD_BITS+DUTY_W-1:DUTY_W]}
             + (prod[0] ? {1'b0, mcand} : '0);

  assign busy    = (count != '0);
  assign product = prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CNT_W'(DUTY_W);
    end else if (busy) begin
      count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= mcand_in;
      prod  <= (PERIOD_BITS+DUTY_W)'(duty);
    end else if (busy) begin
      prod  <= {sum, prod[DUTY_W-1:1]};
    end
  end

endmodule

/* rtl/spc_div.sv */
// bit-serial restoring divider, one quotient bit per cycle
module spc_div
  import spc_pkg::*;
#(
  parameter int DVD_W = TICK_W,
  parameter int DVS_W = FREQ_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] count;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign shifted = {rem, dvd[DVD_W-1]};
  assign ge      = (shifted >= {1'b0, dvs});
  assign diff    = shifted - {1'b0, dvs};

  assign busy     = (count != '0);
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CNT_W'(DVD_W);
    end else if (busy) begin
      count <= count - CNT_W'(1);
    end
  end

  // quotient bits shift in behind the dividend bits
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      dvd <= {dvd[DVD_W-2:0], ge};
      rem <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

endmodule

/* tb/sv/tb_serial_pwm_command_parser_top.sv */
// testbench for the serial pwm command parser: random command streams vs a settings model
`timescale 1ns / 100ps

module tb_serial_pwm_command_parser_top;
  import spc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [OUT_W-1:0]  period;
    logic [OUT_W-1:0]  compare;
    logic [DUTY_W-1:0] duty;
    logic              led_r;
    logic              led_g;
    logic              led_b;
    logic              applied;
  } pwm_settings_t;

  class pwm_settings_model;
    logic [TICK_W-1:0] tick_rate;
    logic [FREQ_W-1:0] freq_limit;
    logic [FREQ_W-1:0] init_period;
    logic              duty_armed;
    logic              freq_armed;
    logic [ACC_W-1:0]  duty_acc;
    logic              duty_seen;
    logic [ACC_W-1:0]  freq_acc;
    logic              freq_seen;
    logic [DUTY_W-1:0] duty_val;
    logic [OUT_W-1:0]  period_val;
    logic [2:0]        leds;
    logic              freq_loaded;
    pwm_settings_t     pending[$];
    int unsigned       mismatches;

    function new();
      tick_rate   = TICK_RATE_RST;
      freq_limit  = FREQ_LIMIT_RST;
      init_period = INITIAL_PERIOD_RST;
      duty_armed  = 1'b0;
      freq_armed  = 1'b0;
      duty_acc    = '0;
      duty_seen   = 1'b0;
      freq_acc    = '0;
      freq_seen   = 1'b0;
      duty_val    = '0;
      period_val  = INITIAL_PERIOD_RST;
      leds        = '0;
      freq_loaded = 1'b0;
      mismatches  = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_TICK_RATE: tick_rate = val[TICK_W-1:0];
        CFG_FREQ_LIMIT: freq_limit = val[FREQ_W-1:0];
        CFG_INITIAL_PERIOD: begin
          init_period = val[FREQ_W-1:0];
          // only takes hold until a frequency command lands
          if (!freq_loaded) period_val = init_period;
        end
        default: ;
      endcase
    endfunction

    function logic [ACC_W-1:0] add_digit(logic [ACC_W-1:0] acc, logic [3:0] d);
      logic [35:0] nxt;
      nxt = 36'(acc) * 36'd10 + 36'(d);
      return (nxt > 36'(ACC_MAX)) ? ACC_MAX : nxt[ACC_W-1:0];
    endfunction

    function void take_char(logic [CHAR_W-1:0] c);
      pwm_settings_t s;
      logic [31:0]   product;
      logic          hit;
      hit = 1'b0;
      if (c == CH_DUTY) begin
        duty_armed = 1'b1;
      end else if (c == CH_FREQ) begin
        freq_armed = 1'b1;
      end else if (c == CH_TERM) begin
        if (duty_seen && duty_acc <= DUTY_MAX) begin
          duty_val = duty_acc[DUTY_W-1:0];
          hit = 1'b1;
        end
        if (freq_seen && freq_acc >= 1 && freq_acc <= 17'(freq_limit)) begin
          period_val = 16'(32'(tick_rate) / 32'(freq_acc));
          freq_loaded = 1'b1;
          hit = 1'b1;
        end
        duty_armed = 1'b0;
        freq_armed = 1'b0;
        duty_acc   = '0;
        freq_acc   = '0;
        duty_seen  = 1'b0;
        freq_seen  = 1'b0;
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
        // duty wins when both modes are armed
        if (duty_armed) begin
          duty_acc  = add_digit(duty_acc, 4'(c - CH_ZERO));
          duty_seen = 1'b1;
        end else if (freq_armed) begin
          freq_acc  = add_digit(freq_acc, 4'(c - CH_ZERO));
          freq_seen = 1'b1;
        end
      end else if (!(duty_armed && freq_armed)) begin
        case (c)
          CH_RED:   leds[0] = ~leds[0];
          CH_GREEN: leds[1] = ~leds[1];
          CH_BLUE:  leds[2] = ~leds[2];
          default: ;
        endcase
      end
      product   = 32'(duty_val) * 32'(period_val);
      s.period  = period_val;
      s.compare = 16'(product / 32'(PCT_DIVISOR));
      s.duty    = duty_val;
      s.led_r   = leds[0];
      s.led_g   = leds[1];
      s.led_b   = leds[2];
      s.applied = hit;
      pending.push_back(s);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        $error("%s: expected %0d, got %0d", field, want, got);
      end
    endfunction

    function void check_settings(pwm_settings_t got);
      pwm_settings_t want;
      if (pending.size() == 0) begin
        mismatches++;
        $error("settings result with no request outstanding");
        return;
      end
      want = pending.pop_front();
      compare_field("period", 32'(want.period), 32'(got.period));
      compare_field("compare", 32'(want.compare), 32'(got.compare));
      compare_field("duty_percent", 32'(want.duty), 32'(got.duty));
      compare_field("led_red", 32'(want.led_r), 32'(got.led_r));
      compare_field("led_green", 32'(want.led_g), 32'(got.led_g));
      compare_field("led_blue", 32'(want.led_b), 32'(got.led_b));
      compare_field("applied", 32'(want.applied), 32'(got.applied));
    endfunction

    function int unsigned outstanding();
      return pending.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  cfg_idx_t             cfg_index = CFG_TICK_RATE;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CHAR_W-1:0]    rx_char = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [OUT_W-1:0]     period;
  logic [OUT_W-1:0]     compare;
  logic [DUTY_W-1:0]    duty_percent;
  logic                 led_red;
  logic                 led_green;
  logic                 led_blue;
  logic                 applied;

  pwm_settings_model pwm = new();
  int unsigned       cycles = 0;
  int unsigned       chars_sent = 0;
  bit                quiet = 1'b0;

  serial_pwm_command_parser_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_char      (rx_char),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .period       (period),
    .compare      (compare),
    .duty_percent (duty_percent),
    .led_red      (led_red),
    .led_green    (led_green),
    .led_blue     (led_blue),
    .applied      (applied)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver side stalls in bursts
  initial begin
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    pwm_settings_t got;
    cycles++;
    if (!rst) begin
      if (in_valid && in_ready) pwm.take_char(rx_char);
      if (out_valid && out_ready) begin
        got = '{period, compare, duty_percent, led_red, led_green, led_blue, applied};
        pwm.check_settings(got);
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_char(input logic [CHAR_W-1:0] c);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_char  <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    pwm.set_reg(idx, val);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // every request answered, then a margin for the slowest terminator
  task automatic settle();
    in_valid <= 1'b0;
    while (pwm.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic string number_text(int unsigned hi);
    case ($urandom_range(0, 9))
      0: return "";
      1: return $sformatf("%0d", $urandom_range(131072, 99999999));
      2: return {"0", $sformatf("%0d", $urandom_range(0, hi))};
      3: return $sformatf("%0d", $urandom_range(0, 20));
      default: return $sformatf("%0d", $urandom_range(0, hi));
    endcase
  endfunction

  task automatic send_random_command();
    int unsigned kind;
    int unsigned fhi;
    int          k;
    string       leds;
    kind = $urandom_range(0, 99);
    fhi  = 32'(pwm.freq_limit) + 32'(pwm.freq_limit) / 16 + 1;
    leds = "rgb";
    k    = $urandom_range(0, 2);
    if (kind < 35) begin
      send_text({"d", number_text(110), ";"});
    end else if (kind < 65) begin
      send_text({"f", number_text(fhi), ";"});
    end else if (kind < 72) begin
      // both armed: digits land in duty, led letters are dropped
      if ($urandom_range(0, 1))
        send_text({"d", number_text(110), "f", leds.substr(k, k), number_text(110), ";"});
      else
        send_text({"f", number_text(fhi), "d", leds.substr(k, k), number_text(110), ";"});
    end else if (kind < 82) begin
      repeat ($urandom_range(1, 3)) begin
        k = $urandom_range(0, 2);
        send_text(leds.substr(k, k));
      end
    end else if (kind < 90) begin
      case ($urandom_range(0, 3))
        0: send_text({"d", number_text(110)});
        1: send_text({"f", number_text(fhi)});
        2: send_text(number_text(200));
        default: send_text(";");
      endcase
    end else begin
      repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] tick, input logic [CFG_W-1:0] flim,
                           input logic [CFG_W-1:0] init, input int unsigned n_chars);
    int unsigned start;
    settle();
    write_reg(CFG_TICK_RATE, tick);
    write_reg(CFG_FREQ_LIMIT, flim);
    write_reg(CFG_INITIAL_PERIOD, init);
    start = chars_sent;
    while (chars_sent - start < n_chars) send_random_command();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // initial_period writes while no frequency is loaded, including zero
    write_reg(CFG_INITIAL_PERIOD, '0);
    send_text("d50;");
    settle();
    write_reg(CFG_INITIAL_PERIOD, 24'hFFFF);
    send_text(";");
    settle();
    write_reg(CFG_INITIAL_PERIOD, 24'(INITIAL_PERIOD_RST));

    send_text("d101;d100;f0;f4096;f1;d;df7rgb;rgb5D");
    send_char(8'h00);
    send_char(8'hFF);

    run_phase(24'(TICK_RATE_RST), 24'(FREQ_LIMIT_RST), 24'(INITIAL_PERIOD_RST), 130);
    run_phase(24'hFFFFFF, 24'hFFFF, 24'hFFFF, 130);
    run_phase(24'd1, 24'd1, 24'd1, 130);
    run_phase(24'd0, 24'd300, 24'd0, 100);
    repeat (3) begin
      run_phase(24'($urandom_range(0, 1) ? $urandom_range(1, 24'hFFFFFF)
                                         : $urandom_range(1, 5000)),
                24'($urandom_range(0, 1) ? $urandom_range(1, 65535) : $urandom_range(1, 200)),
                24'($urandom_range(1, 65535)), 130);
    end
    settle();
    quiet = 1'b1;
    run_phase(24'(TICK_RATE_RST), 24'(FREQ_LIMIT_RST), 24'(INITIAL_PERIOD_RST), 130);
    settle();

    if (pwm.mismatches == 0 && pwm.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
